// ===== rtl/core/hsl2rgb_pkg.sv =====
// Shared constants, types and helper functions of the HSL to RGB converter.
package hsl2rgb_pkg;

  localparam int unsigned HUE_W     = 9;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned VAL_W     = 16;
  localparam int unsigned WGT_W     = 7;
  localparam int unsigned NUM_W     = 22;
  localparam int unsigned RECIP_SH  = 36;
  localparam int unsigned RECIP_W   = 23;
  localparam int unsigned PROD_W    = NUM_W + RECIP_W;
  localparam int unsigned DIVISOR   = 15300;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << RECIP_SH) / DIVISOR);
  localparam int unsigned PIPE_DEPTH = 5;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 24;

  localparam logic [HUE_W:0] HUE_WRAP   = 10'd360;
  localparam logic [HUE_W:0] HUE_WRAP2  = 10'd720;
  localparam logic [HUE_W:0] HUE_THIRD  = 10'd120;
  localparam logic [HUE_W:0] HUE_2THIRD = 10'd240;

  typedef struct packed {
    logic [VAL_W-1:0] v1;
    logic [VAL_W-1:0] diff;
  } ramp_base_t;

  // Weight of the upper intermediate at ramp position t, in sixtieths.
  function automatic logic [WGT_W-1:0] ramp_weight(input logic [HUE_W-1:0] t);
    logic [HUE_W-1:0] down;
    down = HUE_W'(240) - t;
    if (t < HUE_W'(60)) begin
      ramp_weight = WGT_W'(t);
    end else if (t < HUE_W'(180)) begin
      ramp_weight = WGT_W'(60);
    end else if (t < HUE_W'(240)) begin
      ramp_weight = WGT_W'(down);
    end else begin
      ramp_weight = '0;
    end
  endfunction

endpackage

// ===== rtl/core/hsl2rgb_front.sv =====
// Front stages: hue positions, saturation product and the two intermediates.
module hsl2rgb_front
  import hsl2rgb_pkg::*;
(
  input  logic               clk,
  input  logic [1:0]         en,
  input  logic [HUE_W-1:0]   hue_deg,
  input  logic [CH_W-1:0]    saturation,
  input  logic [CH_W-1:0]    lightness,
  output ramp_base_t         base,
  output logic [WGT_W-1:0]   wgt_red,
  output logic [WGT_W-1:0]   wgt_green,
  output logic [WGT_W-1:0]   wgt_blue
);

  logic [HUE_W:0]     hue_ext;
  logic [HUE_W:0]     pos_r_sum;
  logic [HUE_W:0]     pos_b_sum;
  logic [HUE_W-1:0]   pos_g_next;
  logic [HUE_W-1:0]   pos_r_next;
  logic [HUE_W-1:0]   pos_b_next;
  logic [HUE_W-1:0]   pos_g;
  logic [HUE_W-1:0]   pos_r;
  logic [HUE_W-1:0]   pos_b;
  logic [CH_W-1:0]    sat_a;
  logic [CH_W-1:0]    light_a;
  logic [VAL_W-1:0]   ls_a;
  logic [VAL_W+1:0]   l255;
  logic [VAL_W+1:0]   s255;
  logic [VAL_W+1:0]   v2_wide;
  logic [VAL_W+1:0]   v1_wide;
  logic [VAL_W-1:0]   v2_val;
  logic [VAL_W-1:0]   v1_val;

  always_comb begin
    hue_ext   = {1'b0, hue_deg};
    pos_r_sum = hue_ext + HUE_THIRD;
    pos_b_sum = hue_ext + HUE_2THIRD;
    pos_g_next = (hue_ext >= HUE_WRAP) ? HUE_W'(hue_ext - HUE_WRAP) : hue_deg;
    pos_r_next = (pos_r_sum >= HUE_WRAP) ? HUE_W'(pos_r_sum - HUE_WRAP)
                                         : HUE_W'(pos_r_sum);
    if (pos_b_sum >= HUE_WRAP2) begin
      pos_b_next = HUE_W'(pos_b_sum - HUE_WRAP2);
    end else if (pos_b_sum >= HUE_WRAP) begin
      pos_b_next = HUE_W'(pos_b_sum - HUE_WRAP);
    end else begin
      pos_b_next = HUE_W'(pos_b_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pos_g   <= pos_g_next;
      pos_r   <= pos_r_next;
      pos_b   <= pos_b_next;
      sat_a   <= saturation;
      light_a <= lightness;
      ls_a    <= VAL_W'(lightness) * VAL_W'(saturation);
    end
  end

  always_comb begin
    l255 = ({2'b0, light_a, 8'b0}) - (VAL_W+2)'(light_a);
    s255 = ({2'b0, sat_a, 8'b0}) - (VAL_W+2)'(sat_a);
    if (!light_a[CH_W-1]) begin
      v2_wide = l255 + (VAL_W+2)'(ls_a);
    end else begin
      v2_wide = l255 + s255 - (VAL_W+2)'(ls_a);
    end
    v1_wide = (l255 << 1) - v2_wide;
    v2_val  = VAL_W'(v2_wide);
    v1_val  = VAL_W'(v1_wide);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      base.v1   <= v1_val;
      base.diff <= v2_val - v1_val;
      wgt_red   <= ramp_weight(pos_r);
      wgt_green <= ramp_weight(pos_g);
      wgt_blue  <= ramp_weight(pos_b);
    end
  end

endmodule

// ===== rtl/core/hsl2rgb_chan.sv =====
// One colour channel: ramp numerator and division by 15300 over three stages.
module hsl2rgb_chan
  import hsl2rgb_pkg::*;
(
  input  logic               clk,
  input  logic [2:0]         en,
  input  ramp_base_t         base,
  input  logic [WGT_W-1:0]   wgt,
  output logic [CH_W-1:0]    level
);

  logic [NUM_W-1:0]  num_c;
  logic [NUM_W-1:0]  num_d;
  logic [CH_W-1:0]   quot_d;
  logic [PROD_W-1:0] prod;
  logic [NUM_W-1:0]  rem;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      num_c <= NUM_W'(base.v1) * NUM_W'(60) + NUM_W'(base.diff) * NUM_W'(wgt);
    end
  end

  assign prod = PROD_W'(num_c) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      num_d  <= num_c;
      quot_d <= prod[RECIP_SH +: CH_W];
    end
  end

  // The reciprocal estimate is at most one short of the true quotient.
  assign rem = num_d - NUM_W'(quot_d) * NUM_W'(DIVISOR);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      level <= (rem >= NUM_W'(DIVISOR)) ? quot_d + CH_W'(1) : quot_d;
    end
  end

endmodule

// ===== rtl/core/hsl_to_rgb_convert_unit.sv =====
// HSL to RGB converter top level: stream ports and pipeline flow control.
// Converts one HSL colour per beat to 8-bit RGB in a five-stage pipeline: one beat
// is taken every clock unless a stalled output holds the pipeline full, and each
// result passes the front stages and then the channel stages in turn. The stage
// flow control lets a waiting result sit in the output register while empty stages
// behind it keep filling. Hue values of 360 to 511 are taken modulo 360.
module hsl_to_rgb_convert_unit
  import hsl2rgb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,  // hue_deg[8:0], saturation[16:9], lightness[24:17]
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata   // red[7:0], green[15:8], blue[23:16]
);

  logic [PIPE_DEPTH-1:0] vld;
  logic [PIPE_DEPTH-1:0] en;
  ramp_base_t            base;
  logic [WGT_W-1:0]      wgt_red;
  logic [WGT_W-1:0]      wgt_green;
  logic [WGT_W-1:0]      wgt_blue;
  logic [CH_W-1:0]       red;
  logic [CH_W-1:0]       green;
  logic [CH_W-1:0]       blue;

  always_comb begin
    en[PIPE_DEPTH-1] = !vld[PIPE_DEPTH-1] || m_tready;
    for (int k = PIPE_DEPTH - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  hsl2rgb_front u_front (
    .clk        (clk),
    .en         (en[1:0]),
    .hue_deg    (s_tdata[HUE_W-1:0]),
    .saturation (s_tdata[HUE_W +: CH_W]),
    .lightness  (s_tdata[HUE_W+CH_W +: CH_W]),
    .base       (base),
    .wgt_red    (wgt_red),
    .wgt_green  (wgt_green),
    .wgt_blue   (wgt_blue)
  );

  hsl2rgb_chan u_chan_red (
    .clk   (clk),
    .en    (en[4:2]),
    .base  (base),
    .wgt   (wgt_red),
    .level (red)
  );

  hsl2rgb_chan u_chan_green (
    .clk   (clk),
    .en    (en[4:2]),
    .base  (base),
    .wgt   (wgt_green),
    .level (green)
  );

  hsl2rgb_chan u_chan_blue (
    .clk   (clk),
    .en    (en[4:2]),
    .base  (base),
    .wgt   (wgt_blue),
    .level (blue)
  );

  assign s_tready = en[0];
  assign m_tvalid = vld[PIPE_DEPTH-1];
  assign m_tdata  = {blue, green, red};

endmodule

// ===== rtl/core/hsl2rgb_checker.sv =====
// Port-level checker for the HSL to RGB converter and its bind to the top level.
module hsl2rgb_checker
  import hsl2rgb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata
);

  logic [2:0] pending;
  logic       beat_in;
  logic       beat_out;

  assign beat_in  = s_tvalid && s_tready;
  assign beat_out = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(beat_in) - 3'(beat_out);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Result beat changed while stalled.");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> pending != 3'd0)
    else $error("Result beat without a matching input beat.");

  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'(PIPE_DEPTH))
    else $error("More beats in flight than pipeline stages.");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("Input stalled although the output register is empty.");

endmodule

bind hsl_to_rgb_convert_unit hsl2rgb_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
